@@ hw/rtl/assert_macros.svh @@
// assertion macros included by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold on every clock edge outside reset
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);

`endif

@@ hw/rtl/chim_pkg.sv @@
// shared types and constants of the key to index hash map
`timescale 1ns / 1ps

package chim_pkg;

    // field widths of the request and result
    localparam int KEY_W    = 31;
    localparam int INDEX_W  = 12;
    localparam int STATUS_W = 2;

    // digit hash: sum of digit * 17^position, 32 bit wrap
    localparam int          HASH_W   = 32;
    localparam int          DIGIT_W  = 4;
    localparam logic [31:0] HASH_MUL = 32'd17;

    // divide by ten through a reciprocal multiply, exact for 31 bit keys
    localparam logic [31:0] DIV10_RECIP = 32'hCCCCCCCD;
    localparam int          DIV10_SHIFT = 35;
    localparam int          PROD_W      = KEY_W + 32;

    // bucket reduction: restoring remainder, two hash bits per step
    localparam int MOD_BITS_PER_STEP = 2;
    localparam int MOD_STEPS         = HASH_W / MOD_BITS_PER_STEP;
    localparam int MOD_CNT_W         = $clog2(MOD_STEPS);

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 2'd0,
        ST_NOT_FOUND   = 2'd1,
        ST_BUCKET_FULL = 2'd2,
        ST_STORE_FULL  = 2'd3
    } chim_status_t;

    typedef enum logic {
        REQ_INSERT = 1'b0,
        REQ_LOOKUP = 1'b1
    } chim_req_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic         load;
        logic         div_mul;
        logic         digit_step;
        logic         mod_init;
        logic         mod_step;
        logic         fill_rd;
        logic         ins_wr;
        logic         slot_first;
        logic         slot_next;
        logic         key_rd;
        logic         clr_wr;
        logic         res_set;
        chim_status_t res_code;
        logic         res_idx_count;
        logic         res_idx_cand;
        logic         out_load;
    } chim_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic key_zero;
        logic mod_last;
        logic clr_last;
        logic bucket_full;
        logic store_full;
        logic is_lookup;
        logic fill_zero;
        logic slot_last;
        logic key_match;
    } chim_stat_t;

endpackage

@@ hw/rtl/chained_hash_key_index_map_unit.sv @@
// Bucketed hash map from a 31 bit key to a dense index, insert and lookup.
// Request channel: in_valid / in_stall with req_type (0 insert, 1 lookup) and key.
// Result channel: out_valid / out_stall with status and index, one per request.
// A request is taken while in_valid is high and in_stall is low; in_stall stays
// high from the accepting edge until the result sits in the output register.
// Each request runs the digit hash (D decimal digits, up to 10, one reciprocal
// multiply and one subtract per digit), the bucket remainder over the 32 bit
// hash (two bits per step), the bucket fill read and decision, then on a lookup
// a slot table read and a key store read per slot scanned, then the result load
// and an idle state in which the next request is taken. A lookup scans at most
// the filled slots of one bucket, up to SLOTS (16).
// The next request can be taken once the result is loaded, while that result
// may still wait; a stalled result blocks only the loading of the next.
// After reset the bucket fill table is swept to zero, one bucket per cycle,
// with in_stall high; the entry count restarts at zero.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module chained_hash_key_index_map_unit #(
    parameter int BUCKETS = 4096,
    parameter int ENTRIES = 4096,
    parameter int SLOTS   = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          req_type,
    input  logic [chim_pkg::KEY_W-1:0]    key,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [chim_pkg::STATUS_W-1:0] status,
    output logic [chim_pkg::INDEX_W-1:0]  index
);
    import chim_pkg::*;

    chim_cmd_t  cmd;
    chim_stat_t stat;

    // sequencing
    chim_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    // hash, tables and result registers
    chim_dp #(
        .BUCKETS (BUCKETS),
        .ENTRIES (ENTRIES),
        .SLOTS   (SLOTS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .req_type (req_type),
        .key      (key),
        .stat     (stat),
        .status   (status),
        .index    (index)
    );

    // a taken request keeps the request side stalled while it is worked on
    `ASSERT_CLK_RST(a_accept_stalls, clk, rst_n,
        (in_valid && !in_stall) |=> in_stall, "request taken while busy")

    // only a successful request carries a nonzero index
    `ASSERT_CLK_RST(a_index_zero, clk, rst_n,
        out_valid |-> (status == ST_OK || index == '0), "index set on failed request")

    // a fresh result only appears at the end of work on a request
    `ASSERT_CLK_RST(a_result_from_work, clk, rst_n,
        $rose(out_valid) |-> $past(in_stall), "result without a request in work")

endmodule

@@ hw/rtl/chim_ctrl.sv @@
// controller state machine of the key to index hash map
`timescale 1ns / 1ps

module chim_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                out_stall,
    input  chim_pkg::chim_stat_t stat,
    output logic                in_stall,
    output logic                out_valid,
    output chim_pkg::chim_cmd_t cmd
);
    import chim_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_DIGIT,
        S_MOD,
        S_FILL,
        S_DECIDE,
        S_SKEY,
        S_SCMP,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_stall_reg;
    logic   out_valid_reg;
    logic   out_valid_next;

    // next state and commands
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (stat.key_zero)
                begin
                    cmd.mod_init = 1'b1;
                    state_next   = S_MOD;
                end
                else
                begin
                    cmd.div_mul = 1'b1;
                    state_next  = S_DIGIT;
                end
            end
            S_DIGIT:
            begin
                cmd.digit_step = 1'b1;
                state_next     = S_DIV;
            end
            S_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (stat.mod_last)
                begin
                    state_next = S_FILL;
                end
            end
            S_FILL:
            begin
                cmd.fill_rd = 1'b1;
                state_next  = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (!stat.is_lookup)
                begin
                    cmd.res_set = 1'b1;
                    state_next  = S_DONE;
                    if (stat.bucket_full)
                    begin
                        cmd.res_code = ST_BUCKET_FULL;
                    end
                    else if (stat.store_full)
                    begin
                        cmd.res_code = ST_STORE_FULL;
                    end
                    else
                    begin
                        cmd.res_code      = ST_OK;
                        cmd.res_idx_count = 1'b1;
                        cmd.ins_wr        = 1'b1;
                    end
                end
                else if (stat.fill_zero)
                begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = ST_NOT_FOUND;
                    state_next   = S_DONE;
                end
                else
                begin
                    cmd.slot_first = 1'b1;
                    state_next     = S_SKEY;
                end
            end
            S_SKEY:
            begin
                cmd.key_rd = 1'b1;
                state_next = S_SCMP;
            end
            S_SCMP:
            begin
                if (stat.key_match)
                begin
                    cmd.res_set      = 1'b1;
                    cmd.res_code     = ST_OK;
                    cmd.res_idx_cand = 1'b1;
                    state_next       = S_DONE;
                end
                else if (stat.slot_last)
                begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = ST_NOT_FOUND;
                    state_next   = S_DONE;
                end
                else
                begin
                    cmd.slot_next = 1'b1;
                    state_next    = S_SKEY;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result register valid flag
    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // state and registered handshake outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            in_stall_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_stall_reg  <= (state_next != S_IDLE);
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = in_stall_reg;
    assign out_valid = out_valid_reg;

endmodule

@@ hw/rtl/chim_dp.sv @@
// datapath of the key to index hash map: digit hash, bucket reduction, tables
`timescale 1ns / 1ps

module chim_dp #(
    parameter int BUCKETS = 4096,
    parameter int ENTRIES = 4096,
    parameter int SLOTS   = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  chim_pkg::chim_cmd_t            cmd,
    input  logic                           req_type,
    input  logic [chim_pkg::KEY_W-1:0]     key,
    output chim_pkg::chim_stat_t           stat,
    output logic [chim_pkg::STATUS_W-1:0]  status,
    output logic [chim_pkg::INDEX_W-1:0]   index
);
    import chim_pkg::*;

    localparam int BW  = $clog2(BUCKETS);
    localparam int RW  = BW + 1;
    localparam int IW  = $clog2(ENTRIES);
    localparam int CW  = IW + 1;
    localparam int FW  = $clog2(SLOTS + 1);
    localparam int SAW = $clog2(BUCKETS * SLOTS);

    // request and hash registers
    logic [KEY_W-1:0]     key_reg;
    logic                 lookup_reg;
    logic [KEY_W-1:0]     wq_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [HASH_W-1:0]    acc_reg;
    logic [HASH_W-1:0]    weight_reg;
    logic [HASH_W-1:0]    src_reg;
    logic [BW-1:0]        rem_reg;
    logic [MOD_CNT_W-1:0] mcnt_reg;

    // table access registers
    logic [FW-1:0]        fill_q_reg;
    logic [SAW-1:0]       base_reg;
    logic [FW-1:0]        slot_i_reg;
    logic [IW-1:0]        slot_q_reg;
    logic [IW-1:0]        cand_reg;
    logic [KEY_W-1:0]     keyq_reg;
    logic [CW-1:0]        count_reg;
    logic [BW-1:0]        clr_reg;

    // pending and delivered result
    chim_status_t         res_status_reg;
    logic [IW-1:0]        res_index_reg;
    chim_status_t         out_status_reg;
    logic [INDEX_W-1:0]   out_index_reg;

    // tables
    logic [FW-1:0]        fill_mem [BUCKETS];
    logic [IW-1:0]        slot_mem [BUCKETS * SLOTS];
    logic [KEY_W-1:0]     key_mem  [ENTRIES];

    logic [KEY_W-1:0]     quot;
    logic [KEY_W-1:0]     digit_full;
    logic [DIGIT_W-1:0]   digit;
    logic [BW-1:0]        rem_step;
    logic                 fill_we;
    logic [BW-1:0]        fill_waddr;
    logic [FW-1:0]        fill_wdata;
    logic [SAW-1:0]       slot_waddr;
    logic [SAW-1:0]       slot_raddr;
    logic [FW-1:0]        slot_i_inc;
    logic [INDEX_W+IW-1:0] idx_ext;

    // one decimal digit from the registered reciprocal product
    assign quot       = KEY_W'(prod_reg[PROD_W-1:DIV10_SHIFT]);
    assign digit_full = wq_reg - (quot << 3) - (quot << 1);
    assign digit      = digit_full[DIGIT_W-1:0];

    // two restoring remainder steps against the bucket count
    always_comb
    begin
        logic [BW-1:0] r;
        logic [RW-1:0] t;
        r = rem_reg;
        for (int k = 0; k < MOD_BITS_PER_STEP; k++)
        begin
            t = {r, src_reg[HASH_W-1-k]};
            if (t >= RW'(BUCKETS))
            begin
                t = t - RW'(BUCKETS);
            end
            r = t[BW-1:0];
        end
        rem_step = r;
    end

    // hash and scan registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg    <= key;
            lookup_reg <= (req_type == REQ_LOOKUP);
            wq_reg     <= key;
            acc_reg    <= '0;
            weight_reg <= HASH_W'(1);
        end
        if (cmd.div_mul)
        begin
            prod_reg <= PROD_W'(wq_reg) * PROD_W'(DIV10_RECIP);
        end
        if (cmd.digit_step)
        begin
            acc_reg    <= acc_reg + weight_reg * HASH_W'(digit);
            weight_reg <= weight_reg * HASH_MUL;
            wq_reg     <= quot;
        end
        if (cmd.mod_init)
        begin
            rem_reg  <= '0;
            src_reg  <= acc_reg;
            mcnt_reg <= '0;
        end
        if (cmd.mod_step)
        begin
            rem_reg  <= rem_step;
            src_reg  <= src_reg << MOD_BITS_PER_STEP;
            mcnt_reg <= mcnt_reg + 1'b1;
        end
        if (cmd.fill_rd)
        begin
            base_reg <= SAW'(rem_reg * SLOTS);
        end
        if (cmd.slot_first)
        begin
            slot_i_reg <= '0;
        end
        if (cmd.slot_next)
        begin
            slot_i_reg <= slot_i_inc;
        end
        if (cmd.key_rd)
        begin
            cand_reg <= slot_q_reg;
        end
    end

    // bucket fill table, swept to zero after reset
    assign fill_we    = cmd.clr_wr || cmd.ins_wr;
    assign fill_waddr = cmd.clr_wr ? clr_reg : rem_reg;
    assign fill_wdata = cmd.clr_wr ? '0 : FW'(fill_q_reg + 1'b1);

    always_ff @(posedge clk)
    begin
        if (fill_we)
        begin
            fill_mem[fill_waddr] <= fill_wdata;
        end
        if (cmd.fill_rd)
        begin
            fill_q_reg <= fill_mem[rem_reg];
        end
    end

    // bucket slot table
    assign slot_i_inc = FW'(slot_i_reg + 1'b1);
    assign slot_waddr = SAW'(base_reg + SAW'(fill_q_reg));
    assign slot_raddr = cmd.slot_first ? base_reg : SAW'(base_reg + SAW'(slot_i_inc));

    always_ff @(posedge clk)
    begin
        if (cmd.ins_wr)
        begin
            slot_mem[slot_waddr] <= count_reg[IW-1:0];
        end
        if (cmd.slot_first || cmd.slot_next)
        begin
            slot_q_reg <= slot_mem[slot_raddr];
        end
    end

    // key store
    always_ff @(posedge clk)
    begin
        if (cmd.ins_wr)
        begin
            key_mem[count_reg[IW-1:0]] <= key_reg;
        end
        if (cmd.key_rd)
        begin
            keyq_reg <= key_mem[slot_q_reg];
        end
    end

    // entry count and clear sweep address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            clr_reg   <= '0;
        end
        else
        begin
            if (cmd.ins_wr)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.clr_wr)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
        end
    end

    // pending result and output register
    assign idx_ext = {{INDEX_W{1'b0}}, res_index_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.res_set)
        begin
            res_status_reg <= cmd.res_code;
            if (cmd.res_idx_count)
            begin
                res_index_reg <= count_reg[IW-1:0];
            end
            else if (cmd.res_idx_cand)
            begin
                res_index_reg <= cand_reg;
            end
            else
            begin
                res_index_reg <= '0;
            end
        end
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_index_reg  <= idx_ext[INDEX_W-1:0];
        end
    end

    // status to the controller
    assign stat.key_zero    = (wq_reg == '0);
    assign stat.mod_last    = (mcnt_reg == MOD_CNT_W'(MOD_STEPS - 1));
    assign stat.clr_last    = (clr_reg == BW'(BUCKETS - 1));
    assign stat.bucket_full = (fill_q_reg >= FW'(SLOTS));
    assign stat.store_full  = (count_reg >= CW'(ENTRIES));
    assign stat.is_lookup   = lookup_reg;
    assign stat.fill_zero   = (fill_q_reg == '0);
    assign stat.slot_last   = (slot_i_inc == fill_q_reg);
    assign stat.key_match   = (keyq_reg == key_reg);

    assign status = out_status_reg;
    assign index  = out_index_reg;

endmodule

@@ verif/chained_hash_key_index_map_unit_tb.sv @@
// testbench for the bucketed key to index hash map: directed and random requests
`timescale 1ns / 1ps

module chained_hash_key_index_map_unit_tb;

    import chim_pkg::*;

    localparam int BUCKETS = 4096;
    localparam int ENTRIES = 4096;
    localparam int SLOTS   = 16;

    localparam int MIX_ITEMS      = 1880;
    localparam int HOT_BUCKETS    = 3;
    localparam int HOT_KEYS_EACH  = 6;
    localparam int LONG_HOLD      = 3000;
    localparam int LONG_HOLD_AT   = 300;
    localparam int DRAIN_CYCLES   = 100;
    localparam int MAX_PRINTS     = 50;
    localparam longint CYCLE_LIMIT = 5000000;

    localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic                req_type;
    logic [KEY_W-1:0]    key;
    logic                out_valid;
    logic                out_stall;
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  index;

    // shadow hash map and queue of expected results
    class key_index_board #(int NB = 4096, int NE = 4096, int NS = 16);
        typedef struct packed {
            chim_status_t       code;
            logic [INDEX_W-1:0] idx;
        } map_result_t;

        int unsigned        fill_count [NB];
        int unsigned        slot_index [NB*NS];
        logic [KEY_W-1:0]   key_store [NE];
        int unsigned        used_entries;
        map_result_t        pending_results [$];
        int unsigned        fail_count;

        function new();
            foreach (fill_count[i])
                fill_count[i] = 0;
            used_entries = 0;
            fail_count = 0;
        endfunction

        // sum of digit * 17^position with 32 bit wrap, reduced to a bucket
        function int unsigned digit_bucket(logic [KEY_W-1:0] k);
            logic [31:0] acc;
            logic [31:0] weight;
            logic [31:0] rest;
            acc = '0;
            weight = 32'd1;
            rest = {1'b0, k};
            while (rest != 0)
            begin
                acc = acc + weight * (rest % 32'd10);
                weight = weight * 32'd17;
                rest = rest / 32'd10;
            end
            return acc % NB;
        endfunction

        // random key that lands in the given bucket
        function logic [KEY_W-1:0] find_key_in_bucket(int unsigned b);
            logic [KEY_W-1:0] k;
            do
                k = KEY_W'($urandom);
            while (digit_bucket(k) != b);
            return k;
        endfunction

        // update the shadow map for one accepted request
        function void note_request(chim_req_t kind, logic [KEY_W-1:0] k);
            int unsigned b;
            int unsigned fill;
            int unsigned cand;
            bit          found;
            map_result_t want;
            b = digit_bucket(k);
            fill = (fill_count[b] > NS) ? NS : fill_count[b];
            want.code = ST_OK;
            want.idx = '0;
            if (kind == REQ_INSERT)
            begin
                if (fill >= NS)
                    want.code = ST_BUCKET_FULL;
                else if (used_entries >= NE)
                    want.code = ST_STORE_FULL;
                else
                begin
                    want.idx = INDEX_W'(used_entries);
                    key_store[used_entries] = k;
                    slot_index[b*NS + fill] = used_entries;
                    fill_count[b] = fill + 1;
                    used_entries++;
                end
            end
            else
            begin
                // scan the bucket in insertion order, first match wins
                want.code = ST_NOT_FOUND;
                found = 0;
                for (int i = 0; i < fill && !found; i++)
                begin
                    cand = slot_index[b*NS + i];
                    if (cand < NE && key_store[cand] == k)
                    begin
                        want.code = ST_OK;
                        want.idx = INDEX_W'(cand);
                        found = 1;
                    end
                end
            end
            pending_results.push_back(want);
        endfunction

        task report_mismatch(string msg);
            fail_count++;
            if (fail_count <= MAX_PRINTS)
                $display("mismatch at %0t: %s", $realtime, msg);
        endtask

        // compare one delivered result with the oldest expectation
        task check_result(logic [STATUS_W-1:0] st, logic [INDEX_W-1:0] ix);
            map_result_t want;
            if (pending_results.size() == 0)
                report_mismatch($sformatf("result status=%0d index=%0d with no request pending",
                                          st, ix));
            else
            begin
                want = pending_results.pop_front();
                if (st !== want.code)
                    report_mismatch($sformatf("status got %0d want %0d", st, want.code));
                if (ix !== want.idx)
                    report_mismatch($sformatf("index got %0d want %0d", ix, want.idx));
            end
        endtask
    endclass

    key_index_board #(BUCKETS, ENTRIES, SLOTS) board;

    logic [KEY_W-1:0] inserted_keys [$];
    logic [KEY_W-1:0] hot_keys [$];
    int unsigned      accepted_count;
    longint unsigned  cycle_count;

    chained_hash_key_index_map_unit #(
        .BUCKETS (BUCKETS),
        .ENTRIES (ENTRIES),
        .SLOTS   (SLOTS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .key       (key),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .index     (index)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // idle length: mostly none or short, a few long
    function automatic int idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 4);
        else if (r < 98)
            return $urandom_range(5, 30);
        else
            return $urandom_range(31, 150);
    endfunction

    // key with a random number of decimal digits
    function automatic logic [KEY_W-1:0] random_key();
        logic [KEY_W-1:0] k;
        case ($urandom_range(0, 5))
            0: k = KEY_W'($urandom_range(0, 9));
            1: k = KEY_W'($urandom_range(0, 999));
            2: k = KEY_W'($urandom_range(0, 99999));
            default: k = KEY_W'($urandom);
        endcase
        return k;
    endfunction

    function automatic logic [KEY_W-1:0] known_key();
        return inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
    endfunction

    function automatic logic [KEY_W-1:0] hot_key();
        return hot_keys[$urandom_range(0, hot_keys.size() - 1)];
    endfunction

    // offer one request and wait until it is taken
    task automatic send_request(input chim_req_t kind, input logic [KEY_W-1:0] k);
        int gap;
        gap = ((accepted_count / 64) % 4 == 3) ? 0 : idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= kind;
        key <= k;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        board.note_request(kind, k);
        if (kind == REQ_INSERT)
            inserted_keys.push_back(k);
        accepted_count++;
    endtask

    // mixed traffic: inserts, duplicates, hits, misses and crowded buckets
    task automatic mixed_request();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            send_request(REQ_INSERT, random_key());
        else if (pick < 45)
            send_request(REQ_INSERT, hot_key());
        else if (pick < 52)
            send_request(REQ_INSERT, known_key());
        else if (pick < 75)
            send_request(REQ_LOOKUP, known_key());
        else if (pick < 85)
            send_request(REQ_LOOKUP, hot_key());
        else
            send_request(REQ_LOOKUP, random_key());
    endtask

    // stimulus and end of run
    initial
    begin : stimulus
        logic [KEY_W-1:0] zero_mate;
        int unsigned      hb;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        req_type <= REQ_INSERT;
        key <= '0;
        accepted_count = 0;
        board = new();

        // keys that crowd a few buckets, and one that shares bucket zero with key 0
        repeat (HOT_BUCKETS)
        begin
            hb = $urandom_range(1, BUCKETS - 1);
            repeat (HOT_KEYS_EACH)
                hot_keys.push_back(board.find_key_in_bucket(hb));
        end
        zero_mate = board.find_key_in_bucket(0);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty map, key extremes, then bucket zero filled to the top
        send_request(REQ_LOOKUP, '0);
        send_request(REQ_INSERT, '0);
        send_request(REQ_INSERT, KEY_MAX);
        send_request(REQ_LOOKUP, KEY_MAX);
        send_request(REQ_LOOKUP, '0);
        send_request(REQ_LOOKUP, zero_mate);
        repeat (SLOTS - 1)
            send_request(REQ_INSERT, '0);
        send_request(REQ_INSERT, '0);
        send_request(REQ_LOOKUP, zero_mate);
        send_request(REQ_INSERT, zero_mate);
        send_request(REQ_LOOKUP, '0);

        // random traffic
        repeat (MIX_ITEMS)
            mixed_request();
        in_valid <= 1'b0;

        // drain
        while (board.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // result side: check each taken result, stall at random
    initial
    begin : result_sink
        int stall_left;
        int calm_left;
        bit calm;
        bit long_hold_done;
        out_stall <= 1'b0;
        stall_left = 0;
        calm_left = 500;
        calm = 0;
        long_hold_done = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
                board.check_result(status, index);

            // alternate between busy and calm stretches
            if (calm_left == 0)
            begin
                calm = ($urandom_range(0, 2) == 0);
                calm_left = $urandom_range(100, 800);
            end
            else
                calm_left--;

            // one long hold-off so the block backs up into the request side
            if (stall_left == 0 && !long_hold_done && accepted_count >= LONG_HOLD_AT)
            begin
                stall_left = LONG_HOLD;
                long_hold_done = 1;
            end
            else if (stall_left == 0 && !calm && $urandom_range(0, 3) == 0)
                stall_left = idle_len();

            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // watchdog
    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

endmodule

@@ chained_hash_key_index_map_unit.f @@
+incdir+hw/rtl
hw/rtl/chim_pkg.sv
hw/rtl/chim_ctrl.sv
hw/rtl/chim_dp.sv
hw/rtl/chained_hash_key_index_map_unit.sv
verif/chained_hash_key_index_map_unit_tb.sv
